FILE: rtl/ezvad_pkg.sv
// Shared types and constants for the energy / zero-crossing voice detector.
// Used by every module of the block; depends on nothing else.
package ezvad_pkg;

    localparam int SAMPLE_W = 16;
    localparam int SQUARE_W = 32;
    localparam int ENERGY_W = 46;
    localparam int CROSS_W  = 15;
    localparam int COUNT_W  = 16;
    localparam int FLEN_W   = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = ENERGY_W;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ENERGY_THR   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CROSS_THR    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_ACTIVE   = 2'd3;

    localparam logic [FLEN_W-1:0]  FRAME_LENGTH_RST = 16'd320;
    localparam logic [COUNT_W-1:0] MIN_ACTIVE_RST   = 16'd3;

    localparam logic [ENERGY_W-1:0] ENERGY_MAX = {ENERGY_W{1'b1}};
    localparam logic [CROSS_W-1:0]  CROSS_MAX  = {CROSS_W{1'b1}};
    localparam logic [COUNT_W-1:0]  COUNT_MAX  = {COUNT_W{1'b1}};

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last_sample;
    } t_in;

    typedef struct packed {
        logic               voice_detected;
        logic [COUNT_W-1:0] active_frames;
    } t_out;

    // One record per sample leaving the frame accumulator
    typedef struct packed {
        logic                last;
        logic                frame_end;
        logic [ENERGY_W-1:0] energy;
        logic [CROSS_W-1:0]  crossing;
    } t_frame_rec;

endpackage

FILE: rtl/ezvad_frame_acc.sv
// Frame accumulator: input register, square stage, and per-frame energy and
// zero-crossing accumulation. Depends on ezvad_pkg.
module ezvad_frame_acc #(
    parameter int MAX_FRAME = 32768,
    parameter int POS_W     = $clog2(MAX_FRAME),
    parameter int LEN_W     = POS_W + 1
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  ezvad_pkg::t_in          i_in_data,
    output logic                    o_in_ready,
    input  logic [LEN_W-1:0]        i_frame_len,
    output logic                    o_rec_valid,
    output ezvad_pkg::t_frame_rec   o_rec,
    input  logic                    i_rec_ready
);

    // Stage A: input register
    logic           r_a_valid;
    ezvad_pkg::t_in r_a;

    // Stage B: squared sample
    logic                               r_b_valid;
    logic [ezvad_pkg::SQUARE_W-1:0]     r_b_sq;
    logic                               r_b_neg;
    logic                               r_b_last;

    // Stage C: accumulated record
    logic                   r_c_valid;
    ezvad_pkg::t_frame_rec  r_c;

    // Frame state
    logic [ezvad_pkg::ENERGY_W-1:0] r_energy, n_energy;
    logic [ezvad_pkg::CROSS_W-1:0]  r_cross, n_cross;
    logic [POS_W-1:0]               r_pos, n_pos;
    logic                           r_prev_neg, n_prev_neg;

    logic c_free, b_free, a_free, b_go;
    logic a_neg;
    logic [ezvad_pkg::SAMPLE_W:0]   a_ext;
    logic [ezvad_pkg::SAMPLE_W-1:0] a_mag;
    logic [ezvad_pkg::ENERGY_W:0]   e_sum;
    logic [ezvad_pkg::ENERGY_W-1:0] e_acc;
    logic [ezvad_pkg::CROSS_W-1:0]  x_acc;
    logic [LEN_W-1:0]               pos_inc;
    logic                           frame_end;

    assign c_free     = !r_c_valid || i_rec_ready;
    assign b_free     = !r_b_valid || c_free;
    assign a_free     = !r_a_valid || b_free;
    assign b_go       = r_b_valid && c_free;
    assign o_in_ready = a_free;

    // Magnitude of a two's complement sample; the most negative value maps to 2^15
    always_comb begin
        a_neg = r_a.sample[ezvad_pkg::SAMPLE_W-1];
        a_ext = {r_a.sample[ezvad_pkg::SAMPLE_W-1], r_a.sample};
        a_mag = a_neg ? ezvad_pkg::SAMPLE_W'(-a_ext) : ezvad_pkg::SAMPLE_W'(a_ext);
    end

    always_comb begin
        e_sum = {1'b0, r_energy} + (ezvad_pkg::ENERGY_W + 1)'(r_b_sq);
        e_acc = e_sum[ezvad_pkg::ENERGY_W] ? ezvad_pkg::ENERGY_MAX
                                           : e_sum[ezvad_pkg::ENERGY_W-1:0];
        x_acc = r_cross;
        if ((r_pos != '0) && (r_prev_neg != r_b_neg) && (r_cross != ezvad_pkg::CROSS_MAX)) begin
            x_acc = r_cross + 1'b1;
        end
        pos_inc   = LEN_W'(r_pos) + 1'b1;
        frame_end = (pos_inc >= i_frame_len);

        n_energy   = e_acc;
        n_cross    = x_acc;
        n_prev_neg = r_b_neg;
        n_pos      = POS_W'(pos_inc);
        // Clear at a frame boundary and after the final sample of a buffer
        if (frame_end || r_b_last) begin
            n_energy   = '0;
            n_cross    = '0;
            n_prev_neg = 1'b0;
            n_pos      = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid  <= 1'b0;
            r_b_valid  <= 1'b0;
            r_c_valid  <= 1'b0;
            r_energy   <= '0;
            r_cross    <= '0;
            r_pos      <= '0;
            r_prev_neg <= 1'b0;
        end else begin
            if (a_free) begin
                r_a_valid <= i_in_valid;
            end
            if (b_free) begin
                r_b_valid <= r_a_valid;
            end
            if (c_free) begin
                r_c_valid <= r_b_valid;
            end
            if (b_go) begin
                r_energy   <= n_energy;
                r_cross    <= n_cross;
                r_pos      <= n_pos;
                r_prev_neg <= n_prev_neg;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_free && i_in_valid) begin
            r_a <= i_in_data;
        end
        if (b_free && r_a_valid) begin
            r_b_sq   <= a_mag * a_mag;
            r_b_neg  <= a_neg;
            r_b_last <= r_a.last_sample;
        end
        if (b_go) begin
            r_c.last      <= r_b_last;
            r_c.frame_end <= frame_end;
            r_c.energy    <= e_acc;
            r_c.crossing  <= x_acc;
        end
    end

    assign o_rec_valid = r_c_valid;
    assign o_rec       = r_c;

endmodule

FILE: rtl/energy_zcr_voice_detector_core.sv
// Energy and zero-crossing voice detector. Takes one signed 16-bit sample per
// cycle unless stalled, cuts the stream into frames of frame_length samples (zero
// counts as one, values above MAX_FRAME are clamped), and counts frames whose
// energy and sign-change count both exceed their thresholds. A sample marked last
// closes the buffer: one result follows with the saturating active-frame count
// and the voice flag, and a partial trailing frame is dropped. Sustained rate is
// one sample per cycle while the output is not stalled; the result passes from
// the input register through the square, accumulate and output registers. A
// stalled result holds the buffer-closing record, and the pipeline stalls its
// input once the three stages behind it are full. Write configuration only while
// idle.
// Depends on ezvad_pkg and ezvad_frame_acc.
module energy_zcr_voice_detector_core #(
    parameter int MAX_FRAME = 32768
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  ezvad_pkg::t_in                      i_in_data,
    output logic                                o_in_ready,
    output logic                                o_out_valid,
    output ezvad_pkg::t_out                     o_out_data,
    input  logic                                i_out_ready,
    input  logic                                i_cfg_we,
    input  logic [ezvad_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ezvad_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int POS_W = $clog2(MAX_FRAME);
    localparam int LEN_W = POS_W + 1;
    localparam int EXT_W = ezvad_pkg::FLEN_W + 1;

    logic [ezvad_pkg::FLEN_W-1:0]   r_frame_length;
    logic [ezvad_pkg::ENERGY_W-1:0] r_energy_thr;
    logic [ezvad_pkg::CROSS_W-1:0]  r_cross_thr;
    logic [ezvad_pkg::COUNT_W-1:0]  r_min_active;

    logic [ezvad_pkg::COUNT_W-1:0]  r_active, n_active;
    logic                           r_out_valid;
    ezvad_pkg::t_out                r_out;

    logic [EXT_W-1:0]       len_ext;
    logic [LEN_W-1:0]       frame_len;
    logic                   rec_valid, rec_ready, rec_go, out_free;
    ezvad_pkg::t_frame_rec  rec;

    // Clamp the frame length to 1..MAX_FRAME
    always_comb begin
        len_ext = {1'b0, r_frame_length};
        if (len_ext == '0) begin
            len_ext = EXT_W'(1);
        end else if (len_ext > EXT_W'(MAX_FRAME)) begin
            len_ext = EXT_W'(MAX_FRAME);
        end
        frame_len = LEN_W'(len_ext);
    end

    ezvad_frame_acc #(
        .MAX_FRAME (MAX_FRAME),
        .POS_W     (POS_W),
        .LEN_W     (LEN_W)
    ) u_frame_acc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_ready  (o_in_ready),
        .i_frame_len (frame_len),
        .o_rec_valid (rec_valid),
        .o_rec       (rec),
        .i_rec_ready (rec_ready)
    );

    // Only a buffer-closing record needs the output register
    assign out_free  = !r_out_valid || i_out_ready;
    assign rec_ready = !rec.last || out_free;
    assign rec_go    = rec_valid && rec_ready;

    always_comb begin
        n_active = r_active;
        if (rec.frame_end && (rec.energy > r_energy_thr) && (rec.crossing > r_cross_thr)
                && (r_active != ezvad_pkg::COUNT_MAX)) begin
            n_active = r_active + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_length <= ezvad_pkg::FRAME_LENGTH_RST;
            r_energy_thr   <= '0;
            r_cross_thr    <= '0;
            r_min_active   <= ezvad_pkg::MIN_ACTIVE_RST;
            r_active       <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    ezvad_pkg::REG_FRAME_LENGTH: begin
                        r_frame_length <= i_cfg_data[ezvad_pkg::FLEN_W-1:0];
                    end
                    ezvad_pkg::REG_ENERGY_THR: begin
                        r_energy_thr <= i_cfg_data[ezvad_pkg::ENERGY_W-1:0];
                    end
                    ezvad_pkg::REG_CROSS_THR: begin
                        r_cross_thr <= i_cfg_data[ezvad_pkg::CROSS_W-1:0];
                    end
                    ezvad_pkg::REG_MIN_ACTIVE: begin
                        r_min_active <= i_cfg_data[ezvad_pkg::COUNT_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (rec_go && rec.last) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (rec_go) begin
                if (rec.last) begin
                    r_active <= '0;
                end else begin
                    r_active <= n_active;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rec_go && rec.last) begin
            r_out.voice_detected <= (n_active > r_min_active);
            r_out.active_frames  <= n_active;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

FILE: rtl/ezvad_checker.sv
// Port-level checks for the voice detector core, attached by bind.
// Depends on ezvad_pkg and energy_zcr_voice_detector_core.
module ezvad_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            o_out_valid,
    input ezvad_pkg::t_out o_out_data,
    input logic            i_out_ready
);

    // No result may appear in the cycle after reset
    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid straight after reset");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed or dropped");

    // Voice needs at least one active frame
    a_voice_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.voice_detected |-> o_out_data.active_frames != '0)
        else $error("voice flagged with no active frames");

    // Result valid cannot rise unless reset was already released before the rise
    a_no_rise_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_rst_n))
        else $error("result raised during reset");

endmodule

bind energy_zcr_voice_detector_core ezvad_checker u_ezvad_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .o_out_data  (o_out_data),
    .i_out_ready (i_out_ready)
);

FILE: verif/energy_zcr_voice_detector_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for energy_zcr_voice_detector_core: directed corner buffers
// and randomised buffers under bursty input and output stalls.
// Depends on ezvad_pkg and the detector RTL only.
module energy_zcr_voice_detector_core_tb;

    // Per-buffer frame voting, tracked sample by sample, plus the queue of verdicts due
    class frame_vote_checker;
        localparam int LONGEST_FRAME = 32768;

        logic [ezvad_pkg::FLEN_W-1:0]   frame_len;
        logic [ezvad_pkg::ENERGY_W-1:0] energy_thr;
        logic [ezvad_pkg::CROSS_W-1:0]  cross_thr;
        logic [ezvad_pkg::COUNT_W-1:0]  min_active;

        logic [ezvad_pkg::ENERGY_W-1:0] energy;
        logic [ezvad_pkg::CROSS_W-1:0]  crossings;
        logic [ezvad_pkg::FLEN_W-1:0]   pos;
        logic                           prev_neg;
        logic [ezvad_pkg::COUNT_W-1:0]  active;

        ezvad_pkg::t_out verdicts_due[$];
        int              errors;
        int              verdicts_checked;

        function new();
            frame_len        = ezvad_pkg::FRAME_LENGTH_RST;
            energy_thr       = '0;
            cross_thr        = '0;
            min_active       = ezvad_pkg::MIN_ACTIVE_RST;
            active           = '0;
            errors           = 0;
            verdicts_checked = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            energy    = '0;
            crossings = '0;
            pos       = '0;
            prev_neg  = 1'b0;
        endfunction

        function void set_reg(logic [ezvad_pkg::CFG_IDX_W-1:0] idx,
                              logic [ezvad_pkg::CFG_DATA_W-1:0] value);
            case (idx)
                ezvad_pkg::REG_FRAME_LENGTH: frame_len  = value[ezvad_pkg::FLEN_W-1:0];
                ezvad_pkg::REG_ENERGY_THR:   energy_thr = value[ezvad_pkg::ENERGY_W-1:0];
                ezvad_pkg::REG_CROSS_THR:    cross_thr  = value[ezvad_pkg::CROSS_W-1:0];
                ezvad_pkg::REG_MIN_ACTIVE:   min_active = value[ezvad_pkg::COUNT_W-1:0];
                default: ;
            endcase
        endfunction

        function void take_sample(ezvad_pkg::t_in s);
            logic                           neg;
            logic [16:0]                    mag;
            logic [ezvad_pkg::SQUARE_W-1:0] sq;
            logic [ezvad_pkg::ENERGY_W:0]   sum;
            int unsigned                    len;
            ezvad_pkg::t_out                verdict;
            neg = s.sample[ezvad_pkg::SAMPLE_W-1];
            mag = neg ? (17'h10000 - {1'b0, s.sample}) : {1'b0, s.sample};
            sq  = ezvad_pkg::SQUARE_W'(mag) * ezvad_pkg::SQUARE_W'(mag);
            sum = {1'b0, energy} + (ezvad_pkg::ENERGY_W+1)'(sq);
            energy = (sum > ezvad_pkg::ENERGY_MAX) ? ezvad_pkg::ENERGY_MAX
                                                   : sum[ezvad_pkg::ENERGY_W-1:0];

            // no crossing against the tail of the previous frame
            if (pos != 0 && prev_neg != neg && crossings != ezvad_pkg::CROSS_MAX)
                crossings++;
            prev_neg = neg;

            len = (frame_len == 0) ? 1 : frame_len;
            if (len > LONGEST_FRAME)
                len = LONGEST_FRAME;
            if (32'(pos) + 1 >= len) begin
                if (energy > energy_thr && crossings > cross_thr
                        && active != ezvad_pkg::COUNT_MAX)
                    active++;
                clear_frame();
            end else begin
                pos++;
            end

            if (s.last_sample) begin
                verdict.voice_detected = (active > min_active);
                verdict.active_frames  = active;
                verdicts_due.push_back(verdict);
                clear_frame();
                active = '0;
            end
        endfunction

        function void check_verdict(ezvad_pkg::t_out got);
            ezvad_pkg::t_out want;
            if (verdicts_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected result: voice %0b frames %0d", $time,
                         got.voice_detected, got.active_frames);
                return;
            end
            want = verdicts_due.pop_front();
            verdicts_checked++;
            if (got.voice_detected !== want.voice_detected) begin
                errors++;
                $display("%0t: voice_detected mismatch: expected %0b actual %0b", $time,
                         want.voice_detected, got.voice_detected);
            end
            if (got.active_frames !== want.active_frames) begin
                errors++;
                $display("%0t: active_frames mismatch: expected %0d actual %0d", $time,
                         want.active_frames, got.active_frames);
            end
        endfunction

        function int pending();
            return verdicts_due.size();
        endfunction

        function void close_out();
            if (verdicts_due.size() != 0) begin
                errors++;
                $display("%0t: %0d result(s) never arrived, oldest voice %0b frames %0d",
                         $time, verdicts_due.size(), verdicts_due[0].voice_detected,
                         verdicts_due[0].active_frames);
            end
        endfunction
    endclass

    logic                               i_clk;
    logic                               i_rst_n;
    logic                               i_in_valid;
    ezvad_pkg::t_in                     i_in_data;
    logic                               o_in_ready;
    logic                               o_out_valid;
    ezvad_pkg::t_out                    o_out_data;
    logic                               i_out_ready;
    logic                               i_cfg_we;
    logic [ezvad_pkg::CFG_IDX_W-1:0]    i_cfg_index;
    logic [ezvad_pkg::CFG_DATA_W-1:0]   i_cfg_data;

    frame_vote_checker board = new();

    bit steady;          // no input gaps during the clamped-length buffer
    bit hold_req;
    int hold_left;
    int burst_left;
    int samples_sent;
    int buffers_sent;
    int settings_used;
    int cur_eff;

    energy_zcr_voice_detector_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_ready (i_out_ready),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    initial begin
        #20_000_000;
        $display("Verification failed");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            board.check_verdict(o_out_data);
    end

    // Receiver: segments of always-ready, coin-toss and periodic stalls; a requested
    // hold-off overrides all of them for a fixed stretch
    initial begin
        int seg_left;
        int seg_mode;
        int tick;
        i_out_ready = 1'b0;
        seg_left    = 0;
        seg_mode    = 0;
        tick        = 0;
        hold_left   = 0;
        forever begin
            @(negedge i_clk);
            tick++;
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                if (seg_left == 0) begin
                    seg_mode = $urandom_range(0, 2);
                    seg_left = $urandom_range(5, 60);
                end
                seg_left--;
                case (seg_mode)
                    0:       i_out_ready <= 1'b1;
                    1:       i_out_ready <= 1'($urandom_range(0, 1));
                    default: i_out_ready <= (tick % 4 != 0);
                endcase
            end
        end
    end

    task automatic write_reg(input logic [ezvad_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ezvad_pkg::CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        board.set_reg(idx, value);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_sample(input logic signed [ezvad_pkg::SAMPLE_W-1:0] value,
                               input logic is_last);
        ezvad_pkg::t_in item;
        int             gap;
        item.sample      = value;
        item.last_sample = is_last;
        gap = 0;
        if (!steady) begin
            if (burst_left == 0) begin
                gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                burst_left = $urandom_range(1, 40);
            end
            burst_left--;
        end
        repeat (gap) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        board.take_sample(item);
        samples_sent++;
        if (is_last)
            buffers_sent++;
    endtask

    // Drop valid, wait for every verdict, then let the pipeline run dry
    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // 0: full range, 1: near zero, 2: alternating sign, other: extremes
    function automatic logic signed [ezvad_pkg::SAMPLE_W-1:0] pick_sample(int style, int n);
        int mag;
        case (style)
            0: return ezvad_pkg::SAMPLE_W'($urandom);
            1: return ezvad_pkg::SAMPLE_W'(int'($urandom_range(0, 6)) - 3);
            2: begin
                mag = $urandom_range(1, 32767);
                return (n % 2 == 0) ? ezvad_pkg::SAMPLE_W'(mag) : ezvad_pkg::SAMPLE_W'(-mag);
            end
            default: begin
                case ($urandom_range(0, 4))
                    0:       return 16'sh8000;
                    1:       return 16'sh7FFF;
                    2:       return 16'sh0000;
                    3:       return 16'shFFFF;
                    default: return 16'sh0001;
                endcase
            end
        endcase
    endfunction

    task automatic apply_settings(input logic [ezvad_pkg::FLEN_W-1:0]   fl,
                                  input logic [ezvad_pkg::ENERGY_W-1:0] et,
                                  input logic [ezvad_pkg::CROSS_W-1:0]  ct,
                                  input logic [ezvad_pkg::COUNT_W-1:0]  ma);
        // junk in the unused upper data bits must be ignored
        write_reg(ezvad_pkg::REG_FRAME_LENGTH, ezvad_pkg::CFG_DATA_W'({$urandom, fl}));
        write_reg(ezvad_pkg::REG_ENERGY_THR, et);
        write_reg(ezvad_pkg::REG_CROSS_THR, ezvad_pkg::CFG_DATA_W'({$urandom, ct}));
        write_reg(ezvad_pkg::REG_MIN_ACTIVE, ezvad_pkg::CFG_DATA_W'({$urandom, ma}));
        cur_eff = (fl == 0) ? 1 : fl;
        settings_used++;
    endtask

    task automatic pick_settings();
        logic [ezvad_pkg::FLEN_W-1:0]   fl;
        logic [ezvad_pkg::ENERGY_W-1:0] et;
        logic [ezvad_pkg::CROSS_W-1:0]  ct;
        logic [ezvad_pkg::COUNT_W-1:0]  ma;
        int pick;
        int eff;
        pick = $urandom_range(0, 19);
        if (pick < 13)      fl = ezvad_pkg::FLEN_W'($urandom_range(1, 8));
        else if (pick < 15) fl = '0;
        else if (pick < 19) fl = ezvad_pkg::FLEN_W'($urandom_range(9, 64));
        else                fl = ezvad_pkg::FRAME_LENGTH_RST;
        eff = (fl == 0) ? 1 : fl;
        pick = $urandom_range(0, 19);
        if (pick < 5)       et = '0;
        else if (pick < 10) et = ezvad_pkg::ENERGY_W'($urandom_range(0, 1 << 20));
        else if (pick < 18) et = ezvad_pkg::ENERGY_W'(eff)
                                 * ezvad_pkg::ENERGY_W'($urandom_range(0, 1 << 29));
        else                et = ezvad_pkg::ENERGY_MAX;
        pick = $urandom_range(0, 9);
        if (pick < 3)       ct = '0;
        else if (pick < 9)  ct = ezvad_pkg::CROSS_W'($urandom_range(0, eff));
        else                ct = ezvad_pkg::CROSS_MAX;
        pick = $urandom_range(0, 19);
        if (pick < 16)      ma = ezvad_pkg::COUNT_W'($urandom_range(0, 4));
        else if (pick < 18) ma = ezvad_pkg::COUNT_MAX;
        else                ma = ezvad_pkg::COUNT_W'($urandom);
        apply_settings(fl, et, ct, ma);
    endtask

    initial begin
        int nbuf;
        int blen;
        int style;
        int cap;
        bit open_end;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        hold_req    = 1'b0;
        steady      = 1'b0;
        burst_left  = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: short buffer, partial frame dropped
        send_sample(16'sd100, 1'b0);
        send_sample(-16'sd100, 1'b0);
        send_sample(16'sd100, 1'b1);
        drain();

        // zero length acts as one: single-sample frames never cross
        apply_settings(16'd0, '0, '0, '0);
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh8000, 1'b1);
        drain();

        // extremes, and zero counted as positive against minus one
        apply_settings(16'd2, '0, '0, '0);
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh0000, 1'b0);
        send_sample(16'shFFFF, 1'b1);
        drain();

        // shorten the frame mid-way: it closes at the next sample
        apply_settings(16'd4, '0, '0, '0);
        send_sample(16'sd1000, 1'b0);
        send_sample(-16'sd1000, 1'b0);
        send_sample(16'sd1000, 1'b0);
        drain();
        write_reg(ezvad_pkg::REG_FRAME_LENGTH, ezvad_pkg::CFG_DATA_W'(2));
        send_sample(-16'sd1000, 1'b1);
        drain();

        // thresholds at their top: nothing passes
        apply_settings(16'd2, ezvad_pkg::ENERGY_MAX, ezvad_pkg::CROSS_MAX, '0);
        for (int n = 0; n < 4; n++)
            send_sample(n[0] ? 16'sh8000 : 16'sh7FFF, n == 3);
        drain();

        // minimum at its top: no voice however many frames pass
        apply_settings(16'd2, '0, '0, ezvad_pkg::COUNT_MAX);
        for (int n = 0; n < 4; n++)
            send_sample(pick_sample(2, n), n == 3);
        drain();

        // length above the ceiling clamps: a short buffer leaves its frame open
        steady = 1'b1;
        apply_settings(16'hFFFF, '0, ezvad_pkg::CROSS_W'(ezvad_pkg::CROSS_MAX - 1), '0);
        for (int n = 0; n < 6; n++)
            send_sample(n[0] ? 16'sh7FFF : 16'sh8000, n == 5);
        drain();
        steady = 1'b0;

        begin : random_part
            int start_count;
            start_count = samples_sent;
            while (samples_sent - start_count < 880) begin
                drain();
                pick_settings();
                if (settings_used == 10) begin
                    // stall the output for a long stretch while samples keep coming
                    hold_req = 1'b1;
                    for (int n = 0; n < 40; n++)
                        send_sample(pick_sample(0, n), $urandom_range(0, 3) != 0);
                end
                nbuf = $urandom_range(2, 6);
                open_end = ($urandom_range(0, 7) == 0);
                cap = 3 * cur_eff + 2;
                if (cap > 200)
                    cap = 200;
                for (int b = 0; b < nbuf && (samples_sent - start_count) < 880; b++) begin
                    blen  = $urandom_range(1, cap);
                    style = $urandom_range(0, 3);
                    for (int k = 0; k < blen; k++)
                        send_sample(pick_sample(($urandom_range(0, 9) == 0) ?
                                                $urandom_range(0, 3) : style, k),
                                    k == blen - 1 && !(open_end && b == nbuf - 1));
                end
            end
        end
        drain();

        board.close_out();
        $display("Run covered %0d samples in %0d buffers across %0d register settings;",
                 samples_sent, buffers_sent, settings_used);
        $display("%0d results checked, with length clamping, threshold extremes and a hold-off.",
                 board.verdicts_checked);
        if (board.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
